>>> rtl/exponent_binned_float_accumulator_assert.svh
// Assertion macros for the exponent-binned accumulator.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef EXPONENT_BINNED_FLOAT_ACCUMULATOR_ASSERT_SVH
`define EXPONENT_BINNED_FLOAT_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication
`define EBFA_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define EBFA_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ebfa_pkg.sv
// ----------------------------------------------------------------------------
// ebfa_pkg
// Shared types and constants of the exponent-binned accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ebfa_pkg;

    localparam int NUM_BINS  = 256;
    localparam int BIN_W     = $clog2(NUM_BINS);
    localparam int SP_MANT_W = 23;
    localparam int DP_W      = 64;

    localparam logic [DP_W-1:0] DP_POS_ZERO = '0;

    // One binned item on its way from front to back
    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic [DP_W-1:0]  val;
        logic             last;
    } t_job;

endpackage

>>> rtl/ebfa_front.sv
// ----------------------------------------------------------------------------
// ebfa_front
// Accepts single-precision items, widens them to double and picks the bin.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ebfa_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [31:0]         i_partial_sum,
    input  logic                i_last,
    output logic                o_job_vld,
    input  logic                i_job_full,
    output ebfa_pkg::t_job      o_job
);

    logic           r_vld, n_vld;
    ebfa_pkg::t_job r_job, n_job;
    logic           w_accept;
    logic           w_fwd;
    logic [63:0]    w_wide;
    logic           s;
    logic [7:0]     e;
    logic [22:0]    f;
    logic [4:0]     p;
    logic [51:0]    sub_mant;

    // exact float -> double conversion
    always_comb begin
        s = i_partial_sum[31];
        e = i_partial_sum[30:23];
        f = i_partial_sum[22:0];
        p = '0;
        for (int k = 0; k < 23; k++) begin
            if (f[k]) begin
                p = 5'(k);
            end
        end
        sub_mant = 52'({f, 29'b0} << (5'd23 - p));
        if (e == 8'hFF) begin
            if (f == '0) begin
                w_wide = {s, 11'h7FF, 52'b0};
            end else begin
                // signalling NaN gets quieted
                w_wide = {s, 11'h7FF, 1'b1, f[21:0], 29'b0};
            end
        end else if (e == 8'h00) begin
            if (f == '0) begin
                w_wide = {s, 63'b0};
            end else begin
                w_wide = {s, 11'(11'd874 + 11'(p)), sub_mant};
            end
        end else begin
            w_wide = {s, 11'(11'd896 + 11'(e)), f, 29'b0};
        end
    end

    assign full     = r_vld & i_job_full;
    assign w_accept = push & ~full;
    assign w_fwd    = r_vld & ~i_job_full;

    always_comb begin
        n_vld = r_vld;
        n_job = r_job;
        if (w_accept) begin
            n_vld     = 1'b1;
            n_job.bin = i_partial_sum[30:23];
            n_job.val = w_wide;
            n_job.last = i_last;
        end else if (w_fwd) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_job <= n_job;
    end

    assign o_job_vld = r_vld;
    assign o_job     = r_job;

endmodule

>>> rtl/ebfa_fifo.sv
// ----------------------------------------------------------------------------
// ebfa_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ebfa_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ebfa_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ebfa_pkg::t_job o_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    ebfa_pkg::t_job     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [PTR_W-1:0]   r_rp, n_rp;
    logic [PTR_W:0]     r_cnt, n_cnt;
    logic               w_wr, w_rd;

    assign o_full  = (r_cnt == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push & ~o_full;
    assign w_rd    = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp  = w_wr ? r_wp + 1'b1 : r_wp;
        n_rp  = w_rd ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (PTR_W+1)'(w_wr) - (PTR_W+1)'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> rtl/ebfa_dadd.sv
// ----------------------------------------------------------------------------
// ebfa_dadd
// Three-stage double-precision adder, round to nearest even.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ebfa_dadd (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_vld,
    output logic [63:0] o_sum
);

    // stage A: specials, swap, align
    logic        r_a_vld, r_a_spc, r_a_sx, r_a_sy, r_a_sub;
    logic [63:0] r_a_spv;
    logic [10:0] r_a_ex;
    logic [55:0] r_a_mx, r_a_my;
    // stage B: add, leading-zero count
    logic        r_b_vld, r_b_spc, r_b_sx, r_b_sy, r_b_sub;
    logic [63:0] r_b_spv;
    logic [10:0] r_b_ex;
    logic [56:0] r_b_sum;
    logic [5:0]  r_b_lz;
    // stage C: result
    logic        r_c_vld;
    logic [63:0] r_c_res;

    logic        a_nan, b_nan, a_inf, b_inf;
    logic        swp;
    logic [63:0] x, y;
    logic [10:0] ex, ey, d;
    logic [55:0] mx, my, ysh, ymask;
    logic        ysticky;
    logic        n_spc;
    logic [63:0] n_spv;
    logic [55:0] n_my;

    always_comb begin
        a_nan = (i_a[62:52] == 11'h7FF) && (i_a[51:0] != '0);
        b_nan = (i_b[62:52] == 11'h7FF) && (i_b[51:0] != '0);
        a_inf = (i_a[62:52] == 11'h7FF) && (i_a[51:0] == '0);
        b_inf = (i_b[62:52] == 11'h7FF) && (i_b[51:0] == '0);
        n_spc = 1'b1;
        if (a_nan) begin
            n_spv = i_a | (64'd1 << 51);
        end else if (b_nan) begin
            n_spv = i_b | (64'd1 << 51);
        end else if (a_inf && b_inf && (i_a[63] != i_b[63])) begin
            n_spv = 64'hFFF8_0000_0000_0000;
        end else if (a_inf) begin
            n_spv = i_a;
        end else if (b_inf) begin
            n_spv = i_b;
        end else begin
            n_spc = 1'b0;
            n_spv = '0;
        end
        swp = (i_b[62:0] > i_a[62:0]);
        x   = swp ? i_b : i_a;
        y   = swp ? i_a : i_b;
        ex  = (x[62:52] == '0) ? 11'd1 : x[62:52];
        ey  = (y[62:52] == '0) ? 11'd1 : y[62:52];
        mx  = {(x[62:52] != '0), x[51:0], 3'b0};
        my  = {(y[62:52] != '0), y[51:0], 3'b0};
        d   = ex - ey;
        ysh     = my >> d[5:0];
        ymask   = ~(56'hFF_FFFF_FFFF_FFFF << d[5:0]);
        ysticky = |(my & ymask);
        if (d >= 11'd56) begin
            n_my = {55'b0, (my != '0)};
        end else begin
            n_my = {ysh[55:1], ysh[0] | ysticky};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
        end
        r_a_spc <= n_spc;
        r_a_spv <= n_spv;
        r_a_sx  <= x[63];
        r_a_sy  <= y[63];
        r_a_sub <= x[63] ^ y[63];
        r_a_ex  <= ex;
        r_a_mx  <= mx;
        r_a_my  <= n_my;
    end

    logic [56:0] sum_b;
    logic [5:0]  lz_b;

    always_comb begin
        sum_b = r_a_sub ? ({1'b0, r_a_mx} - {1'b0, r_a_my})
                        : ({1'b0, r_a_mx} + {1'b0, r_a_my});
        lz_b = 6'd56;
        for (int k = 0; k < 56; k++) begin
            if (sum_b[k]) begin
                lz_b = 6'(55 - k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_spc <= r_a_spc;
        r_b_spv <= r_a_spv;
        r_b_sx  <= r_a_sx;
        r_b_sy  <= r_a_sy;
        r_b_sub <= r_a_sub;
        r_b_ex  <= r_a_ex;
        r_b_sum <= sum_b;
        r_b_lz  <= lz_b;
    end

    logic [55:0] m;
    logic [11:0] e;
    logic [10:0] lim, sh;
    logic        inc;
    logic [53:0] mr;
    logic [11:0] ef;
    logic [51:0] frac;
    logic        hid;
    logic [63:0] res_c;

    always_comb begin
        lim = r_b_ex - 11'd1;
        sh  = (11'(r_b_lz) < lim) ? 11'(r_b_lz) : lim;
        if (r_b_sum[56]) begin
            m = {r_b_sum[56:2], r_b_sum[1] | r_b_sum[0]};
            e = {1'b0, r_b_ex} + 12'd1;
        end else begin
            m = r_b_sum[55:0] << sh[5:0];
            e = {1'b0, r_b_ex} - {1'b0, sh};
        end
        inc = m[2] & (m[1] | m[0] | m[3]);
        mr  = {1'b0, m[55:3]} + 54'(inc);
        if (mr[53]) begin
            ef   = e + 12'd1;
            frac = mr[52:1];
            hid  = 1'b1;
        end else begin
            ef   = e;
            frac = mr[51:0];
            hid  = mr[52];
        end
        if (r_b_spc) begin
            res_c = r_b_spv;
        end else if (r_b_sum == '0) begin
            // exact zero: negative only when both addends were negative
            res_c = {r_b_sx & r_b_sy & ~r_b_sub, 63'b0};
        end else if (ef >= 12'd2047) begin
            res_c = {r_b_sx, 11'h7FF, 52'b0};
        end else begin
            res_c = {r_b_sx, hid ? ef[10:0] : 11'd0, frac};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c_res <= res_c;
    end

    assign o_vld = r_c_vld;
    assign o_sum = r_c_res;

endmodule

>>> rtl/ebfa_back.sv
// ----------------------------------------------------------------------------
// ebfa_back
// Bin memory, read-modify-write per item, descending walk on the last item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "exponent_binned_float_accumulator_assert.svh"

module ebfa_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_empty,
    input  ebfa_pkg::t_job i_job,
    output logic           o_job_pop,
    input  logic           i_res_pop,
    output logic           o_res_empty,
    output logic [63:0]    o_total
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_WRD   = 3'd3;
    localparam logic [2:0] S_WADD  = 3'd4;
    localparam logic [2:0] S_WWAIT = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    localparam int BW = ebfa_pkg::BIN_W;

    logic [2:0]                   r_st, n_st;
    ebfa_pkg::t_job               r_job, n_job;
    logic [BW-1:0]                r_idx, n_idx;
    logic [63:0]                  r_tot, n_tot;
    logic [63:0]                  r_out, n_out;
    logic                         r_out_vld, n_out_vld;
    logic [ebfa_pkg::NUM_BINS-1:0] r_bvld, n_bvld;
    logic [63:0]                  r_mem [ebfa_pkg::NUM_BINS];
    logic [63:0]                  r_rd_data;
    logic                         r_rd_ok;
    logic [BW-1:0]                w_rd_addr;
    logic                         w_we;
    logic [63:0]                  w_rd_val;
    logic                         w_add_vld;
    logic [63:0]                  w_add_a, w_add_b, w_add_sum;
    logic                         w_add_done;

    assign w_rd_addr = (r_st == S_IDLE) ? i_job.bin : r_idx;
    assign w_rd_val  = r_rd_ok ? r_rd_data : ebfa_pkg::DP_POS_ZERO;
    assign o_job_pop = (r_st == S_IDLE) & ~i_job_empty;
    assign w_we      = (r_st == S_WAIT) & w_add_done;

    always_comb begin
        w_add_vld = 1'b0;
        w_add_a   = w_rd_val;
        w_add_b   = r_job.val;
        if (r_st == S_RD) begin
            w_add_vld = 1'b1;
        end else if (r_st == S_WADD) begin
            w_add_vld = 1'b1;
            w_add_a   = r_tot;
            w_add_b   = w_rd_val;
        end
    end

    ebfa_dadd u_dadd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_add_vld),
        .i_a     (w_add_a),
        .i_b     (w_add_b),
        .o_vld   (w_add_done),
        .o_sum   (w_add_sum)
    );

    always_comb begin
        n_st      = r_st;
        n_job     = r_job;
        n_idx     = r_idx;
        n_tot     = r_tot;
        n_out     = r_out;
        n_out_vld = r_out_vld & ~i_res_pop;
        n_bvld    = r_bvld;
        case (r_st)
            S_IDLE: begin
                if (!i_job_empty) begin
                    n_job = i_job;
                    n_st  = S_RD;
                end
            end
            S_RD: n_st = S_WAIT;
            S_WAIT: begin
                if (w_add_done) begin
                    n_bvld[r_job.bin] = 1'b1;
                    if (r_job.last) begin
                        n_tot = ebfa_pkg::DP_POS_ZERO;
                        n_idx = '1;
                        n_st  = S_WRD;
                    end else begin
                        n_st = S_IDLE;
                    end
                end
            end
            S_WRD:  n_st = S_WADD;
            S_WADD: n_st = S_WWAIT;
            S_WWAIT: begin
                if (w_add_done) begin
                    n_tot = w_add_sum;
                    if (r_idx == '0) begin
                        n_st = S_EMIT;
                    end else begin
                        n_idx = r_idx - 1'b1;
                        n_st  = S_WRD;
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_vld) begin
                    n_out     = r_tot;
                    n_out_vld = 1'b1;
                    n_bvld    = '0;
                    n_st      = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_out_vld <= 1'b0;
            r_bvld    <= '0;
        end else begin
            r_st      <= n_st;
            r_out_vld <= n_out_vld;
            r_bvld    <= n_bvld;
        end
        r_job <= n_job;
        r_idx <= n_idx;
        r_tot <= n_tot;
        r_out <= n_out;
    end

    // bin memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_job.bin] <= w_add_sum;
        end
        r_rd_data <= r_mem[w_rd_addr];
        r_rd_ok   <= r_bvld[w_rd_addr];
    end

    assign o_res_empty = ~r_out_vld;
    assign o_total     = r_out;

    `EBFA_AST_IMP(a_add_done_waiting, w_add_done, (r_st == S_WAIT) || (r_st == S_WWAIT), "adder result with no waiting step")
    `EBFA_AST_NXT(a_walk_descends, (r_st == S_WWAIT) && w_add_done && (r_idx != '0), (r_idx == $past(r_idx) - 1'b1) && (r_st == S_WRD), "walk index did not step down")
    `EBFA_AST_NXT(a_emit_clears, (r_st == S_EMIT) && !r_out_vld, (r_bvld == '0) && r_out_vld, "total emitted without clearing bins")

endmodule

>>> rtl/exponent_binned_float_accumulator.sv
// ----------------------------------------------------------------------------
// exponent_binned_float_accumulator
// Bins float partial sums by exponent into double bins; sums bins on last.
// ----------------------------------------------------------------------------
// channel | direction | handshake       | fields
// input   | in        | push / full     | i_partial_sum[31:0], i_last
// result  | out       | empty / pop     | o_total[63:0]
//
// In the back part each item passes the job pop, the bin read and the 3-stage adder.
// A last item then adds a walk over all 256 bins, highest first, through the same
// adder before the total lands in the result register.
// Reset clears all bins at once through per-bin valid bits.
// The front and a 4-deep queue keep taking items while the back part is busy, until they fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module exponent_binned_float_accumulator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_partial_sum,
    input  logic        i_last,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_total
);

    logic           w_fr_vld;
    ebfa_pkg::t_job w_fr_job;
    logic           w_q_full;
    logic           w_q_empty;
    logic           w_q_pop;
    ebfa_pkg::t_job w_q_job;

    ebfa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_partial_sum (i_partial_sum),
        .i_last        (i_last),
        .o_job_vld     (w_fr_vld),
        .i_job_full    (w_q_full),
        .o_job         (w_fr_job)
    );

    ebfa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fr_vld),
        .i_data  (w_fr_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_job)
    );

    ebfa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (w_q_empty),
        .i_job       (w_q_job),
        .o_job_pop   (w_q_pop),
        .i_res_pop   (pop),
        .o_res_empty (empty),
        .o_total     (o_total)
    );

endmodule
